// ===== src/rast_pkg.sv =====
package rast_pkg;

    localparam int LEAVES = 1024;
    localparam int H      = $clog2(LEAVES);
    localparam int NW     = H + 1;
    localparam int IW     = H + 2;
    localparam int LW     = $clog2(H + 1);
    localparam int DEPTH  = 2 * LEAVES;
    localparam int TW     = 48;
    localparam int VW     = 32;
    localparam int PW     = 11;

    localparam logic [1:0] MODE_ASSIGN = 2'd0;
    localparam logic [1:0] MODE_SUM    = 2'd1;
    localparam logic [1:0] MODE_TAKE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]    mode;
        logic [10:0]   left;
        logic [10:0]   right;
        logic [VW-1:0] value;
        logic [TW-1:0] limit;
    } t_in_item;

    typedef struct packed {
        logic [TW-1:0] sum;
        logic [PW-1:0] position;
        logic [TW-1:0] remaining;
    } t_out_item;

    typedef struct packed {
        logic          flag;
        logic [VW-1:0] pval;
        logic [TW-1:0] total;
    } t_node;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_CLR, CMD_LOAD, CMD_KA, CMD_KB, CMD_RD_K,
        CMD_PUSH0, CMD_PUSH1, CMD_PUSH2, CMD_LVL_DEC, CMD_LVL_INC,
        CMD_LOOP_INIT, CMD_LOOP_L, CMD_LOOP_R, CMD_LOOP_SH,
        CMD_UPD_INIT, CMD_RD_C0, CMD_RD_C1, CMD_UPD_W,
        CMD_DESC_INIT, CMD_D_STEP, CMD_OUT_SUM, CMD_OUT_HI, CMD_OUT_LO
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       empty;
        logic       need_a;
        logic       need_b;
        logic       flag;
        logic       loop_more;
        logic       lvl_top;
        logic       lvl_one;
        logic       leaf;
        logic       node_fits;
        logic       clr_last;
        logic       out_free;
    } t_status;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_START, S_PA, S_PB, S_PRD, S_PCHK, S_PW1, S_PW2,
        S_PNEXT, S_LINIT, S_LCHK, S_LL, S_LR, S_LSH, S_UINIT, S_UA, S_UB,
        S_UR0, S_UR1, S_UW, S_UNEXT, S_OSUM, S_DINIT, S_DRD, S_DCHK,
        S_DLRD, S_DLCHK
    } t_state;

    typedef enum logic [1:0] {RET_A, RET_B, RET_D} t_ret;

    function automatic logic [TW-1:0] span(input logic [VW-1:0] v,
                                           input logic [LW-1:0] s);
        return TW'(v) << s;
    endfunction

endpackage

// ===== src/rast_dp.sv =====
module rast_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rast_pkg::t_cmd       i_cmd,
    input  rast_pkg::t_in_item   i_in_item,
    input  logic                 i_out_ready,
    output rast_pkg::t_status    o_status,
    output logic                 o_out_valid,
    output rast_pkg::t_out_item  o_out_item
);

    localparam int NW = rast_pkg::NW;
    localparam int IW = rast_pkg::IW;
    localparam int LW = rast_pkg::LW;
    localparam int TW = rast_pkg::TW;
    localparam int VW = rast_pkg::VW;
    localparam int H  = rast_pkg::H;

    rast_pkg::t_node r_mem [rast_pkg::DEPTH];
    rast_pkg::t_node r_rdata;

    logic [NW-1:0] r_ca, r_k;
    logic [LW-1:0] r_i;
    logic [IW-1:0] r_l, r_r, r_l0, r_r0;
    logic [1:0]    r_mode;
    logic [VW-1:0] r_val, r_pv;
    logic [TW-1:0] r_limit, r_acc, r_lim, r_pt, r_tmp;
    logic [H:0]    r_lo;
    logic          r_ov, r_addp;
    rast_pkg::t_out_item r_out;

    logic            we, re, add_req;
    logic [NW-1:0]   waddr, raddr, k_a, k_b, l_node, r_node;
    rast_pkg::t_node wdata;
    logic [LW-1:0]   i_m1;
    logic [IW-1:0]   mask, r_m1;
    logic [H:0]      lft_c, rgt_c, half, full;
    logic            out_load;

    assign i_m1   = LW'(r_i - 1'b1);
    assign mask   = ~({IW{1'b1}} << r_i);
    assign r_m1   = r_r - 1'b1;
    assign k_a    = NW'(r_l0 >> r_i);
    assign k_b    = NW'((r_r0 - 1'b1) >> r_i);
    assign l_node = r_l[NW-1:0];
    assign r_node = r_m1[NW-1:0];
    assign half   = (H+1)'(1) << i_m1;
    assign full   = (H+1)'(1) << r_i;
    assign lft_c  = (32'(i_in_item.left) > rast_pkg::LEAVES) ?
                    (H+1)'(rast_pkg::LEAVES) : (H+1)'(i_in_item.left);
    assign rgt_c  = (32'(i_in_item.right) > rast_pkg::LEAVES) ?
                    (H+1)'(rast_pkg::LEAVES) : (H+1)'(i_in_item.right);
    assign out_load = (i_cmd == rast_pkg::CMD_OUT_SUM) ||
                      (i_cmd == rast_pkg::CMD_OUT_HI) ||
                      (i_cmd == rast_pkg::CMD_OUT_LO);

    always_comb begin
        we      = 1'b0;
        re      = 1'b0;
        add_req = 1'b0;
        waddr   = '0;
        raddr   = '0;
        wdata   = '0;
        unique case (i_cmd)
            rast_pkg::CMD_CLR: begin
                we    = 1'b1;
                waddr = r_ca;
            end
            rast_pkg::CMD_RD_K: begin
                re    = 1'b1;
                raddr = r_k;
            end
            rast_pkg::CMD_PUSH0: begin
                we    = 1'b1;
                waddr = {r_k[NW-2:0], 1'b0};
                wdata = '{flag: 1'b1, pval: r_rdata.pval,
                          total: rast_pkg::span(r_rdata.pval, i_m1)};
            end
            rast_pkg::CMD_PUSH1: begin
                we    = 1'b1;
                waddr = {r_k[NW-2:0], 1'b1};
                wdata = '{flag: 1'b1, pval: r_pv, total: rast_pkg::span(r_pv, i_m1)};
            end
            rast_pkg::CMD_PUSH2: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = '{flag: 1'b0, pval: r_pv, total: r_pt};
            end
            rast_pkg::CMD_LOOP_L: begin
                if (r_l[0]) begin
                    if (r_mode == rast_pkg::MODE_ASSIGN) begin
                        we    = 1'b1;
                        waddr = l_node;
                        wdata = '{flag: 1'b1, pval: r_val,
                                  total: rast_pkg::span(r_val, r_i)};
                    end else begin
                        re      = 1'b1;
                        raddr   = l_node;
                        add_req = 1'b1;
                    end
                end
            end
            rast_pkg::CMD_LOOP_R: begin
                if (r_r[0]) begin
                    if (r_mode == rast_pkg::MODE_ASSIGN) begin
                        we    = 1'b1;
                        waddr = r_node;
                        wdata = '{flag: 1'b1, pval: r_val,
                                  total: rast_pkg::span(r_val, r_i)};
                    end else begin
                        re      = 1'b1;
                        raddr   = r_node;
                        add_req = 1'b1;
                    end
                end
            end
            rast_pkg::CMD_RD_C0: begin
                re    = 1'b1;
                raddr = {r_k[NW-2:0], 1'b0};
            end
            rast_pkg::CMD_RD_C1: begin
                re    = 1'b1;
                raddr = {r_k[NW-2:0], 1'b1};
            end
            rast_pkg::CMD_UPD_W: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = '{flag: 1'b0, pval: '0, total: r_tmp + r_rdata.total};
            end
            default: ;
        endcase
    end

    // node store
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca   <= '0;
            r_ov   <= 1'b0;
            r_addp <= 1'b0;
        end else begin
            r_addp <= add_req;
            if (i_cmd == rast_pkg::CMD_CLR) begin
                r_ca <= r_ca + 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_addp) begin
            r_acc <= r_acc + r_rdata.total;
        end
        unique case (i_cmd)
            rast_pkg::CMD_LOAD: begin
                r_mode  <= i_in_item.mode;
                r_val   <= i_in_item.value;
                r_limit <= i_in_item.limit;
                r_acc   <= '0;
                r_i     <= LW'(H);
                if (i_in_item.mode == rast_pkg::MODE_TAKE) begin
                    r_l0 <= IW'(rast_pkg::LEAVES);
                    r_r0 <= IW'(rast_pkg::LEAVES) + IW'(lft_c);
                end else begin
                    r_l0 <= IW'(rast_pkg::LEAVES) + IW'(lft_c);
                    r_r0 <= IW'(rast_pkg::LEAVES) + IW'(rgt_c);
                end
            end
            rast_pkg::CMD_KA: r_k <= k_a;
            rast_pkg::CMD_KB: r_k <= k_b;
            rast_pkg::CMD_PUSH0: begin
                r_pv <= r_rdata.pval;
                r_pt <= r_rdata.total;
            end
            rast_pkg::CMD_LVL_DEC: r_i <= i_m1;
            rast_pkg::CMD_LVL_INC: r_i <= LW'(r_i + 1'b1);
            rast_pkg::CMD_LOOP_INIT: begin
                r_i   <= '0;
                r_l   <= r_l0;
                r_r   <= r_r0;
                r_acc <= '0;
            end
            rast_pkg::CMD_LOOP_L: begin
                if (r_l[0]) begin
                    r_l <= r_l + 1'b1;
                end
            end
            rast_pkg::CMD_LOOP_R: begin
                if (r_r[0]) begin
                    r_r <= r_m1;
                end
            end
            rast_pkg::CMD_LOOP_SH: begin
                r_l <= r_l >> 1;
                r_r <= r_r >> 1;
                r_i <= LW'(r_i + 1'b1);
            end
            rast_pkg::CMD_UPD_INIT: r_i <= LW'(1);
            rast_pkg::CMD_RD_C1: r_tmp <= r_rdata.total;
            rast_pkg::CMD_DESC_INIT: begin
                r_k   <= NW'(1);
                r_i   <= LW'(H);
                r_lo  <= '0;
                r_lim <= r_limit + r_acc;
            end
            rast_pkg::CMD_D_STEP: begin
                r_i <= i_m1;
                if (r_rdata.total <= r_lim) begin
                    r_lim <= r_lim - r_rdata.total;
                    r_k   <= {r_k[NW-2:0], 1'b1};
                    r_lo  <= r_lo + half;
                end else begin
                    r_k <= {r_k[NW-2:0], 1'b0};
                end
            end
            rast_pkg::CMD_OUT_SUM: begin
                r_out <= '{sum: r_acc, position: '0, remaining: '0};
            end
            rast_pkg::CMD_OUT_HI: begin
                r_out <= '{sum: '0, position: rast_pkg::PW'(r_lo + full),
                           remaining: r_lim - r_rdata.total};
            end
            rast_pkg::CMD_OUT_LO: begin
                r_out <= '{sum: '0, position: rast_pkg::PW'(r_lo), remaining: r_lim};
            end
            default: ;
        endcase
    end

    always_comb begin
        o_status.mode      = r_mode;
        o_status.empty     = r_l0 >= r_r0;
        o_status.need_a    = |(r_l0 & mask);
        o_status.need_b    = |(r_r0 & mask);
        o_status.flag      = r_rdata.flag;
        o_status.loop_more = r_l < r_r;
        o_status.lvl_top   = r_i == LW'(H);
        o_status.lvl_one   = r_i == LW'(1);
        o_status.leaf      = r_i == '0;
        o_status.node_fits = r_rdata.total <= r_lim;
        o_status.clr_last  = r_ca == NW'(rast_pkg::DEPTH - 1);
        o_status.out_free  = !r_ov || i_out_ready;
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

// ===== src/rast_ctrl.sv =====
module rast_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rast_pkg::t_status i_status,
    output logic              o_in_ready,
    output rast_pkg::t_cmd    o_cmd
);

    rast_pkg::t_state r_state, n_state;
    rast_pkg::t_ret   r_ret, n_ret;
    rast_pkg::t_state ret_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rast_pkg::S_CLR;
            r_ret   <= rast_pkg::RET_A;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_comb begin
        unique case (r_ret)
            rast_pkg::RET_A: ret_state = rast_pkg::S_PB;
            rast_pkg::RET_B: ret_state = rast_pkg::S_PNEXT;
            rast_pkg::RET_D: ret_state = rast_pkg::S_DLRD;
            default:         ret_state = rast_pkg::S_PNEXT;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd      = rast_pkg::CMD_IDLE;
        o_in_ready = 1'b0;
        unique case (r_state)
            rast_pkg::S_CLR: begin
                o_cmd = rast_pkg::CMD_CLR;
                if (i_status.clr_last) n_state = rast_pkg::S_IDLE;
            end
            rast_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd   = rast_pkg::CMD_LOAD;
                    n_state = rast_pkg::S_START;
                end
            end
            rast_pkg::S_START: begin
                if (i_status.mode == rast_pkg::MODE_NONE) begin
                    n_state = rast_pkg::S_IDLE;
                end else if (!i_status.empty) begin
                    n_state = rast_pkg::S_PA;
                end else if (i_status.mode == rast_pkg::MODE_ASSIGN) begin
                    n_state = rast_pkg::S_IDLE;
                end else if (i_status.mode == rast_pkg::MODE_SUM) begin
                    n_state = rast_pkg::S_OSUM;
                end else begin
                    n_state = rast_pkg::S_DINIT;
                end
            end
            rast_pkg::S_PA: begin
                if (i_status.need_a) begin
                    o_cmd   = rast_pkg::CMD_KA;
                    n_ret   = rast_pkg::RET_A;
                    n_state = rast_pkg::S_PRD;
                end else begin
                    n_state = rast_pkg::S_PB;
                end
            end
            rast_pkg::S_PB: begin
                if (i_status.need_b) begin
                    o_cmd   = rast_pkg::CMD_KB;
                    n_ret   = rast_pkg::RET_B;
                    n_state = rast_pkg::S_PRD;
                end else begin
                    n_state = rast_pkg::S_PNEXT;
                end
            end
            rast_pkg::S_PRD: begin
                o_cmd   = rast_pkg::CMD_RD_K;
                n_state = rast_pkg::S_PCHK;
            end
            rast_pkg::S_PCHK: begin
                if (i_status.flag) begin
                    o_cmd   = rast_pkg::CMD_PUSH0;
                    n_state = rast_pkg::S_PW1;
                end else begin
                    n_state = ret_state;
                end
            end
            rast_pkg::S_PW1: begin
                o_cmd   = rast_pkg::CMD_PUSH1;
                n_state = rast_pkg::S_PW2;
            end
            rast_pkg::S_PW2: begin
                o_cmd   = rast_pkg::CMD_PUSH2;
                n_state = ret_state;
            end
            rast_pkg::S_PNEXT: begin
                if (i_status.lvl_one) begin
                    n_state = rast_pkg::S_LINIT;
                end else begin
                    o_cmd   = rast_pkg::CMD_LVL_DEC;
                    n_state = rast_pkg::S_PA;
                end
            end
            rast_pkg::S_LINIT: begin
                o_cmd   = rast_pkg::CMD_LOOP_INIT;
                n_state = rast_pkg::S_LCHK;
            end
            rast_pkg::S_LCHK: begin
                if (i_status.loop_more) begin
                    n_state = rast_pkg::S_LL;
                end else if (i_status.mode == rast_pkg::MODE_ASSIGN) begin
                    n_state = rast_pkg::S_UINIT;
                end else if (i_status.mode == rast_pkg::MODE_SUM) begin
                    n_state = rast_pkg::S_OSUM;
                end else begin
                    n_state = rast_pkg::S_DINIT;
                end
            end
            rast_pkg::S_LL: begin
                o_cmd   = rast_pkg::CMD_LOOP_L;
                n_state = rast_pkg::S_LR;
            end
            rast_pkg::S_LR: begin
                o_cmd   = rast_pkg::CMD_LOOP_R;
                n_state = rast_pkg::S_LSH;
            end
            rast_pkg::S_LSH: begin
                o_cmd   = rast_pkg::CMD_LOOP_SH;
                n_state = rast_pkg::S_LCHK;
            end
            rast_pkg::S_UINIT: begin
                o_cmd   = rast_pkg::CMD_UPD_INIT;
                n_state = rast_pkg::S_UA;
            end
            rast_pkg::S_UA: begin
                if (i_status.need_a) begin
                    o_cmd   = rast_pkg::CMD_KA;
                    n_ret   = rast_pkg::RET_A;
                    n_state = rast_pkg::S_UR0;
                end else begin
                    n_state = rast_pkg::S_UB;
                end
            end
            rast_pkg::S_UB: begin
                if (i_status.need_b) begin
                    o_cmd   = rast_pkg::CMD_KB;
                    n_ret   = rast_pkg::RET_B;
                    n_state = rast_pkg::S_UR0;
                end else begin
                    n_state = rast_pkg::S_UNEXT;
                end
            end
            rast_pkg::S_UR0: begin
                o_cmd   = rast_pkg::CMD_RD_C0;
                n_state = rast_pkg::S_UR1;
            end
            rast_pkg::S_UR1: begin
                o_cmd   = rast_pkg::CMD_RD_C1;
                n_state = rast_pkg::S_UW;
            end
            rast_pkg::S_UW: begin
                o_cmd   = rast_pkg::CMD_UPD_W;
                n_state = (r_ret == rast_pkg::RET_A) ? rast_pkg::S_UB : rast_pkg::S_UNEXT;
            end
            rast_pkg::S_UNEXT: begin
                if (i_status.lvl_top) begin
                    n_state = rast_pkg::S_IDLE;
                end else begin
                    o_cmd   = rast_pkg::CMD_LVL_INC;
                    n_state = rast_pkg::S_UA;
                end
            end
            rast_pkg::S_OSUM: begin
                if (i_status.out_free) begin
                    o_cmd   = rast_pkg::CMD_OUT_SUM;
                    n_state = rast_pkg::S_IDLE;
                end
            end
            rast_pkg::S_DINIT: begin
                o_cmd   = rast_pkg::CMD_DESC_INIT;
                n_state = rast_pkg::S_DRD;
            end
            rast_pkg::S_DRD: begin
                o_cmd   = rast_pkg::CMD_RD_K;
                n_state = rast_pkg::S_DCHK;
            end
            rast_pkg::S_DCHK: begin
                if (i_status.node_fits) begin
                    if (i_status.out_free) begin
                        o_cmd   = rast_pkg::CMD_OUT_HI;
                        n_state = rast_pkg::S_IDLE;
                    end
                end else if (i_status.leaf) begin
                    if (i_status.out_free) begin
                        o_cmd   = rast_pkg::CMD_OUT_LO;
                        n_state = rast_pkg::S_IDLE;
                    end
                end else if (i_status.flag) begin
                    o_cmd   = rast_pkg::CMD_PUSH0;
                    n_ret   = rast_pkg::RET_D;
                    n_state = rast_pkg::S_PW1;
                end else begin
                    n_state = rast_pkg::S_DLRD;
                end
            end
            rast_pkg::S_DLRD: begin
                o_cmd   = rast_pkg::CMD_RD_C0;
                n_state = rast_pkg::S_DLCHK;
            end
            rast_pkg::S_DLCHK: begin
                o_cmd   = rast_pkg::CMD_D_STEP;
                n_state = rast_pkg::S_DRD;
            end
            default: n_state = rast_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== src/range_assign_sum_tree.sv =====
// lazy segment tree over 1024 elements: range assign, range sum, take
// input channel i_in_valid / o_in_ready carries one item per operation:
//   mode assign sets [left,right) to value and returns nothing
//   mode sum returns the wrapped 48-bit total of [left,right)
//   mode take adds the prefix before left to limit and walks down the
//   tree, returning the end position and the budget left over
//   the unused mode is dropped without a result
// output channel o_out_valid / i_out_ready carries one result item
// reset: the node store is swept to zero, one node a cycle; o_in_ready
//   stays low until the sweep is done
// one item is worked at a time through a single node memory with one
//   read and one write per cycle, so the memory port sets the cost of
//   each step: boundary pushes on each of 10 levels, then the covering
//   loop, then for assign a parent refresh on each level, and for take
//   a descent from the root to the end position
// the result sits in an output register; a stalled receiver holds the
//   block only when the next result is ready to be written
module range_assign_sum_tree (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rast_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rast_pkg::t_out_item o_out_item
);

    // command and status between sequencer and datapath
    rast_pkg::t_cmd    cmd;
    rast_pkg::t_status status;

    // sequencer: push, cover, refresh and descent phases
    rast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // node memory, index registers, accumulator and output register
    rast_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== src/rast_checker.sv =====
module rast_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input rast_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rast_pkg::t_out_item o_out_item
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("result changed while stalled");

    // store sweep runs first after reset
    a_clear: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_in_ready)
        else $error("item taken during store sweep");

    // no result appears the cycle after an item is taken
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early");

endmodule

bind range_assign_sum_tree rast_checker u_rast_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NLEAF     = rast_pkg::LEAVES;
    localparam int          CYC_LIMIT = 1000000;
    localparam int          HOLD_LEN  = 3000;
    localparam logic [47:0] M48       = 48'hFFFF_FFFF_FFFF;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    rast_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    rast_pkg::t_out_item o_out_item;

    range_assign_sum_tree DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the tree: span totals, pending assignment value and flag
    logic [47:0] tree_total [2*NLEAF];
    logic [31:0] tree_pval  [2*NLEAF];
    bit          tree_pflag [2*NLEAF];

    rast_pkg::t_in_item  items_to_send [$];
    rast_pkg::t_out_item results_due   [$];

    int send_idle_pct = 15;
    int recv_idle_pct = 86;
    int errors        = 0;
    int cycles        = 0;
    int n_accepted    = 0;
    int n_checked     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    function automatic logic [47:0] fill_total(int len, logic [31:0] v);
        longint unsigned p;
        p = longint'(len) * longint'(v);
        return p[47:0];
    endfunction

    // hand a pending assignment on to both children
    function automatic void push_tag(int v, int len);
        if (v >= NLEAF || !tree_pflag[v]) return;
        tree_pval[2*v]    = tree_pval[v];
        tree_pval[2*v+1]  = tree_pval[v];
        tree_pflag[2*v]   = 1'b1;
        tree_pflag[2*v+1] = 1'b1;
        tree_total[2*v]   = fill_total(len / 2, tree_pval[v]);
        tree_total[2*v+1] = fill_total(len / 2, tree_pval[v]);
        tree_pflag[v]     = 1'b0;
    endfunction

    function automatic void assign_span(int i, int j, logic [31:0] val,
                                        int lo, int hi, int v);
        int mid;
        if (i == lo && j == hi) begin
            tree_pval[v]  = val;
            tree_pflag[v] = 1'b1;
            tree_total[v] = fill_total(hi - lo, val);
            return;
        end
        if (v >= NLEAF) return;
        push_tag(v, hi - lo);
        mid = (lo + hi) / 2;
        if (i < mid) assign_span(i, (j < mid) ? j : mid, val, lo, mid, 2*v);
        if (mid < j) assign_span((i > mid) ? i : mid, j, val, mid, hi, 2*v+1);
        tree_total[v] = tree_total[2*v] + tree_total[2*v+1];
    endfunction

    function automatic logic [47:0] span_sum(int i, int j, int lo, int hi, int v);
        int mid;
        logic [47:0] acc;
        acc = '0;
        if (i == lo && j == hi) return tree_total[v];
        if (tree_pflag[v]) return fill_total(j - i, tree_pval[v]);
        if (v >= NLEAF) return '0;
        mid = (lo + hi) / 2;
        if (i < mid) acc += span_sum(i, (j < mid) ? j : mid, lo, mid, 2*v);
        if (mid < j) acc += span_sum((i > mid) ? i : mid, j, mid, hi, 2*v+1);
        return acc;
    endfunction

    function automatic logic [47:0] clipped_sum(int l, int r);
        if (r > NLEAF) r = NLEAF;
        if (l < r) return span_sum(l, r, 0, NLEAF, 1);
        return '0;
    endfunction

    // apply one accepted item to the shadow tree, queue its result if any
    function automatic void apply_item(rast_pkg::t_in_item it);
        int                  l, r, v, lo, hi, mid;
        logic [47:0]         budget;
        rast_pkg::t_out_item res;
        l = int'(it.left);
        r = int'(it.right);
        res = '0;
        case (it.mode)
            rast_pkg::MODE_ASSIGN: begin
                if (r > NLEAF) r = NLEAF;
                if (l < r) assign_span(l, r, it.value, 0, NLEAF, 1);
            end
            rast_pkg::MODE_SUM: begin
                res.sum = clipped_sum(l, r);
                results_due.push_back(res);
            end
            rast_pkg::MODE_TAKE: begin
                budget = it.limit + clipped_sum(0, l);
                v = 1;
                lo = 0;
                hi = NLEAF;
                forever begin
                    if (tree_total[v] <= budget) begin
                        res.position  = hi[10:0];
                        res.remaining = budget - tree_total[v];
                        break;
                    end
                    if (v >= NLEAF) begin
                        res.position  = lo[10:0];
                        res.remaining = budget;
                        break;
                    end
                    push_tag(v, hi - lo);
                    v   = 2 * v;
                    mid = (lo + hi) / 2;
                    if (tree_total[v] <= budget) begin
                        budget = budget - tree_total[v];
                        v++;
                        lo = mid;
                    end else begin
                        hi = mid;
                    end
                end
                results_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
        $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
        errors++;
    endtask

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // driver: offer pending items, keep valid and payload until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                apply_item(i_in_item);
                n_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                // still waiting for the block to take the item
            end else if (items_to_send.size() > 0 &&
                         $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_item  <= items_to_send.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_LEN;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        rast_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result", o_out_item.sum, '0);
            end else begin
                want = results_due.pop_front();
                n_checked++;
                if (o_out_item.sum !== want.sum)
                    report_mismatch("sum", o_out_item.sum, want.sum);
                if (o_out_item.position !== want.position)
                    report_mismatch("position", 48'(o_out_item.position),
                                    48'(want.position));
                if (o_out_item.remaining !== want.remaining)
                    report_mismatch("remaining", o_out_item.remaining, want.remaining);
            end
        end
    end

    function automatic rast_pkg::t_in_item make_item(logic [1:0] m, int l, int r,
                                                     logic [31:0] v, logic [47:0] lim);
        rast_pkg::t_in_item it;
        it.mode  = m;
        it.left  = l[10:0];
        it.right = r[10:0];
        it.value = v;
        it.limit = lim;
        return it;
    endfunction

    // random budget: small, near the tree total, or anything at all
    function automatic logic [47:0] rand_limit();
        logic [47:0] x;
        x = 48'({$urandom, $urandom});
        case ($urandom_range(3))
            0: return x;
            1: return x >> $urandom_range(47);
            2: return x >> (32 + $urandom_range(15));
            default: return x >> (6 + $urandom_range(12));
        endcase
    endfunction

    function automatic rast_pkg::t_in_item rand_item();
        int          sel, l, r, w;
        logic [1:0]  m;
        logic [31:0] v;
        sel = $urandom_range(99);
        if (sel < 40)      m = rast_pkg::MODE_ASSIGN;
        else if (sel < 70) m = rast_pkg::MODE_SUM;
        else if (sel < 95) m = rast_pkg::MODE_TAKE;
        else               m = rast_pkg::MODE_NONE;
        case ($urandom_range(9))
            0: begin
                // anything the 11-bit fields hold, empty and clipped ranges too
                l = $urandom_range(2047);
                r = $urandom_range(2047);
            end
            1: begin
                l = 0;
                r = NLEAF + $urandom_range(1);
            end
            2: begin
                l = $urandom_range(NLEAF - 1);
                r = l + 1;
            end
            default: begin
                w = 1 << $urandom_range(10);
                l = $urandom_range(NLEAF - 1);
                r = l + 1 + $urandom_range(w - 1);
                if (r > NLEAF) r = NLEAF;
            end
        endcase
        v = $urandom;
        if ($urandom_range(3) == 0) v = v >> $urandom_range(31);
        return make_item(m, l, r, v, rand_limit());
    endfunction

    task automatic wait_drained();
        while (items_to_send.size() > 0 || i_in_valid || results_due.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: field extremes, empty ranges, clipping, unused mode
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 0, NLEAF, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 0, 0, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 0, NLEAF, 32'hFFFF_FFFF, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 0, NLEAF, 0, M48));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 0, 2047, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 2047, 2047, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 500, 500, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 700, 3, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 9, 9, 32'h1234_5678, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 1023, 2047, 32'h0000_0001, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 0, 1, '0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 0, 0, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 0, 0, 0, M48));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 2047, 0, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, NLEAF, 2047, 0, 48'd5));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 1, 0, 0, 48'hFFFF_FFFF));
        items_to_send.push_back(make_item(rast_pkg::MODE_NONE, 0, NLEAF, 32'hFFFF_FFFF, M48));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 100, 612, 32'hA5A5_5A5A, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 99, 613, 0, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_TAKE, 200, 0, 0, 48'h0123_4567_89AB));
        items_to_send.push_back(make_item(rast_pkg::MODE_ASSIGN, 3, 4, 32'h8000_0000, '0));
        items_to_send.push_back(make_item(rast_pkg::MODE_SUM, 0, NLEAF, 0, '0));
        wait_drained();

        // sender mostly busy, receiver mostly stalled
        for (k = 0; k < 280; k++) items_to_send.push_back(rand_item());
        wait_drained();

        send_idle_pct = 86;
        recv_idle_pct = 15;
        for (k = 0; k < 280; k++) items_to_send.push_back(rand_item());
        wait_drained();

        // no idling, plus one long receiver hold-off to back the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (k = 0; k < 290; k++) items_to_send.push_back(rand_item());
        repeat (50) @(posedge i_clk);
        hold_req = hold_req + 1;
        wait_drained();
        repeat (400) @(posedge i_clk);

        $display("%0d items accepted, %0d results checked", n_accepted, n_checked);
        $display("covered range assign, range sum and take under three idling mixes");
        if (errors == 0 && results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
